// File: rtl/core/dms_pkg.sv
package dms_pkg;

  // Operating modes, shared by requests, state and results.
  typedef enum logic [1:0] {
    MODE_STANDBY  = 2'd0,
    MODE_ONROAD   = 2'd1,
    MODE_OFFROAD  = 2'd2,
    MODE_SAFESTOP = 2'd3
  } mode_t;

  // Pending transition direction.
  typedef enum logic [1:0] {
    TR_NONE   = 2'd0,
    TR_TO_OFF = 2'd1,
    TR_TO_ON  = 2'd2
  } trans_t;

  // Selected planning source.
  typedef enum logic [1:0] {
    ROUTE_STOP = 2'd0,
    ROUTE_ON   = 2'd1,
    ROUTE_OFF  = 2'd2
  } route_t;

  // Item kinds.
  typedef enum logic {
    CMD_REQUEST = 1'b0,
    CMD_UPDATE  = 1'b1
  } cmd_t;

  // Reason codes reported with each result word.
  typedef enum logic [3:0] {
    RSN_NONE          = 4'd0,
    RSN_NO_LOC        = 4'd1,
    RSN_AWAIT_SOURCE  = 4'd2,
    RSN_OFF_TO_ON     = 4'd3,
    RSN_OFF_NO_FALLBK = 4'd4,
    RSN_ON_STAY_OFF   = 4'd5,
    RSN_ON_NO_FALLBK  = 4'd6,
    RSN_ON_LOST       = 4'd7,
    RSN_OFF_LOST      = 4'd8,
    RSN_UNSUPPORTED   = 4'd9,
    RSN_ALREADY       = 4'd10,
    RSN_STARTED       = 4'd11
  } reason_t;

  // Register map.
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;
  localparam logic [2:0] REG_AGE_LIMIT   = 3'd0;
  localparam logic [2:0] REG_TRANS_LIMIT = 3'd1;
  localparam logic [2:0] REG_POS_LIMIT   = 3'd2;
  localparam logic [2:0] REG_YAW_LIMIT   = 3'd3;
  localparam logic [2:0] REG_VEL_LIMIT   = 3'd4;
  localparam logic [2:0] REG_STARTUP_OFF = 3'd5;

  // Reset values of the registers.
  localparam logic [15:0] RST_AGE_LIMIT   = 16'd500;
  localparam logic [15:0] RST_TRANS_LIMIT = 16'd3000;
  localparam logic [15:0] RST_POS_LIMIT   = 16'd20;
  localparam logic [31:0] RST_POS_LIM_SQ  = 32'd400;
  localparam logic [11:0] RST_YAW_LIMIT   = 12'd114;
  localparam logic [11:0] RST_VEL_LIMIT   = 12'd20;

  // Packed pose layout.
  localparam int unsigned POS_W = 20;
  localparam int unsigned YAW_W = 12;
  localparam int unsigned VEL_W = 12;
  localparam int unsigned SQ_W  = 2 * POS_W;

  // Queue between the classifier and the state machine.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  typedef struct packed {
    logic [15:0] age_limit;
    logic [15:0] trans_limit;
    logic [15:0] pos_limit;
    logic [11:0] yaw_limit;
    logic [11:0] vel_limit;
    logic        startup_offroad;
  } cfg_t;

  // A classified input word as the back end consumes it.
  typedef struct packed {
    cmd_t        cmd;
    mode_t       target;
    logic        force_req;
    logic [31:0] now_ms;
    logic        ego_valid;
    logic        on_ok;
    logic        off_ok;
    logic        on_cont;
    logic        off_cont;
  } item_t;

  // One result word.
  typedef struct packed {
    logic    accepted;
    mode_t   mode;
    trans_t  trans;
    mode_t   requested;
    route_t  route;
    logic    offroad_active;
    reason_t reason;
  } result_t;

endpackage

// File: rtl/core/driving_mode_supervisor_unit.sv
// Channel  | Direction | Handshake            | Word
// ---------+-----------+----------------------+---------------------------------------
// input    | in        | in_valid / in_stall  | cmd, target, force, time, pose, sources
// output   | out       | out_valid / out_stall| accepted, modes, route, reason
// config   | in        | APB psel / penable   | six limit and startup registers
//
// One word per cycle is sustained while the output is not stalled. A word enters the first
// classifier stage (differences) as it is taken, then passes the squares on four multipliers,
// a queue slot, and the state update into the output register.
// Reset is synchronous and clears the pipeline, the four-slot queue and the state.
// An output stall holds the result; the queue absorbs words in flight, and the input
// stalls only once the queue and both classifier stages are full.
module driving_mode_supervisor_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cmd,
  input  logic [1:0]                   target_mode,
  input  logic                         force_req,
  input  logic [31:0]                  now_ms,
  input  logic                         ego_valid,
  input  logic [63:0]                  ego_pose,
  input  logic [1:0]                   onroad_flags,
  input  logic [15:0]                  onroad_age_ms,
  input  logic [63:0]                  onroad_start,
  input  logic [1:0]                   offroad_flags,
  input  logic [15:0]                  offroad_age_ms,
  input  logic [63:0]                  offroad_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         accepted,
  output logic [1:0]                   mode_now,
  output logic [1:0]                   transition_now,
  output logic [1:0]                   requested_now,
  output logic [1:0]                   route,
  output logic                         offroad_active,
  output logic [3:0]                   reason_code,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dms_pkg::PADDR_W-1:0]  paddr,
  input  logic [dms_pkg::PDATA_W-1:0]  pwdata,
  output logic [dms_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import dms_pkg::*;

  cfg_t    cfg;
  logic    q_full;
  logic    q_empty;
  logic    push;
  logic    pop;
  item_t   push_item;
  item_t   head_item;
  result_t result;

  dms_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dms_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .target_mode    (target_mode),
    .force_req      (force_req),
    .now_ms         (now_ms),
    .ego_valid      (ego_valid),
    .ego_pose       (ego_pose),
    .onroad_flags   (onroad_flags),
    .onroad_age_ms  (onroad_age_ms),
    .onroad_start   (onroad_start),
    .offroad_flags  (offroad_flags),
    .offroad_age_ms (offroad_age_ms),
    .offroad_start  (offroad_start),
    .q_full         (q_full),
    .push           (push),
    .push_item      (push_item)
  );

  dms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head_item (head_item)
  );

  dms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .pop       (pop),
    .head      (head_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  // Result word onto the output ports.
  assign accepted       = result.accepted;
  assign mode_now       = result.mode;
  assign transition_now = result.trans;
  assign requested_now  = result.requested;
  assign route          = result.route;
  assign offroad_active = result.offroad_active;
  assign reason_code    = result.reason;

endmodule

// File: rtl/core/dms_cfg.sv
module dms_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dms_pkg::PADDR_W-1:0]  paddr,
  input  logic [dms_pkg::PDATA_W-1:0]  pwdata,
  output logic [dms_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output dms_pkg::cfg_t                cfg
);
  import dms_pkg::*;

  logic [2:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;

  // Register writes; addresses past the last register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.age_limit       <= RST_AGE_LIMIT;
      cfg.trans_limit     <= RST_TRANS_LIMIT;
      cfg.pos_limit       <= RST_POS_LIMIT;
      cfg.yaw_limit       <= RST_YAW_LIMIT;
      cfg.vel_limit       <= RST_VEL_LIMIT;
      cfg.startup_offroad <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_AGE_LIMIT:   cfg.age_limit       <= pwdata[15:0];
        REG_TRANS_LIMIT: cfg.trans_limit     <= pwdata[15:0];
        REG_POS_LIMIT:   cfg.pos_limit       <= pwdata[15:0];
        REG_YAW_LIMIT:   cfg.yaw_limit       <= pwdata[11:0];
        REG_VEL_LIMIT:   cfg.vel_limit       <= pwdata[11:0];
        REG_STARTUP_OFF: cfg.startup_offroad <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      REG_AGE_LIMIT:   prdata = {16'b0, cfg.age_limit};
      REG_TRANS_LIMIT: prdata = {16'b0, cfg.trans_limit};
      REG_POS_LIMIT:   prdata = {16'b0, cfg.pos_limit};
      REG_YAW_LIMIT:   prdata = {20'b0, cfg.yaw_limit};
      REG_VEL_LIMIT:   prdata = {20'b0, cfg.vel_limit};
      REG_STARTUP_OFF: prdata = {31'b0, cfg.startup_offroad};
      default:         prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/dms_front.sv
module dms_front (
  input  logic           clk,
  input  logic           rst,
  input  dms_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           cmd,
  input  logic [1:0]     target_mode,
  input  logic           force_req,
  input  logic [31:0]    now_ms,
  input  logic           ego_valid,
  input  logic [63:0]    ego_pose,
  input  logic [1:0]     onroad_flags,
  input  logic [15:0]    onroad_age_ms,
  input  logic [63:0]    onroad_start,
  input  logic [1:0]     offroad_flags,
  input  logic [15:0]    offroad_age_ms,
  input  logic [63:0]    offroad_start,
  input  logic           q_full,
  output logic           push,
  output dms_pkg::item_t push_item
);
  import dms_pkg::*;

  // Absolute difference of two signed 20-bit coordinates.
  function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    logic [POS_W:0] d;
    logic [POS_W:0] n;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    n = -d;
    return d[POS_W] ? n[POS_W-1:0] : d[POS_W-1:0];
  endfunction

  // Heading and speed parts of the continuity check.
  function automatic logic yaw_vel_ok(input logic [63:0] ego, input logic [63:0] src,
                                      input logic [11:0] yaw_lim,
                                      input logic [11:0] vel_lim);
    logic [YAW_W-1:0] dyaw;
    logic [YAW_W:0]   wrap;
    logic [YAW_W-1:0] ygap;
    logic [VEL_W:0]   dv;
    logic [VEL_W:0]   ndv;
    logic [VEL_W-1:0] vgap;
    dyaw = ego[51:40] - src[51:40];
    wrap = 13'd4096 - {1'b0, dyaw};
    ygap = (dyaw <= 12'd2048) ? dyaw : wrap[YAW_W-1:0];
    dv   = {ego[63], ego[63:52]} - {src[63], src[63:52]};
    ndv  = -dv;
    vgap = dv[VEL_W] ? ndv[VEL_W-1:0] : dv[VEL_W-1:0];
    return (ygap <= yaw_lim) && (vgap <= vel_lim);
  endfunction

  logic             adv1;
  logic             adv2;
  logic [31:0]      lim_sq;

  // Stage one: differences and cheap checks.
  logic             s1_valid;
  item_t            s1_item;
  logic [POS_W-1:0] s1_adx_on;
  logic [POS_W-1:0] s1_ady_on;
  logic [POS_W-1:0] s1_adx_off;
  logic [POS_W-1:0] s1_ady_off;
  logic             s1_yv_on;
  logic             s1_yv_off;

  // Stage two: squares.
  logic             s2_valid;
  item_t            s2_item;
  logic [SQ_W-1:0]  s2_sqx_on;
  logic [SQ_W-1:0]  s2_sqy_on;
  logic [SQ_W-1:0]  s2_sqx_off;
  logic [SQ_W-1:0]  s2_sqy_off;
  logic             s2_yv_on;
  logic             s2_yv_off;

  logic [SQ_W:0]    d2_on;
  logic [SQ_W:0]    d2_off;

  // A stage moves when it is empty or the next stage moves; the last word waits while the queue is full.
  assign adv2     = !s2_valid || !q_full;
  assign adv1     = !s1_valid || adv2;
  assign in_stall = !adv1;

  // Squared position limit, kept beside the limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lim_sq <= RST_POS_LIM_SQ;
    end else begin
      lim_sq <= 32'(cfg.pos_limit) * 32'(cfg.pos_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= in_valid;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
    end
  end

  // Stage one payload.
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_item.cmd       <= cmd_t'(cmd);
      s1_item.target    <= mode_t'(target_mode);
      s1_item.force_req <= force_req;
      s1_item.now_ms    <= now_ms;
      s1_item.ego_valid <= ego_valid;
      s1_item.on_ok     <= (onroad_flags == 2'b11) && (onroad_age_ms <= cfg.age_limit);
      s1_item.off_ok    <= (offroad_flags == 2'b11) && (offroad_age_ms <= cfg.age_limit);
      s1_item.on_cont   <= 1'b0;
      s1_item.off_cont  <= 1'b0;
      s1_adx_on  <= abs_diff(ego_pose[19:0], onroad_start[19:0]);
      s1_ady_on  <= abs_diff(ego_pose[39:20], onroad_start[39:20]);
      s1_adx_off <= abs_diff(ego_pose[19:0], offroad_start[19:0]);
      s1_ady_off <= abs_diff(ego_pose[39:20], offroad_start[39:20]);
      s1_yv_on   <= yaw_vel_ok(ego_pose, onroad_start, cfg.yaw_limit, cfg.vel_limit);
      s1_yv_off  <= yaw_vel_ok(ego_pose, offroad_start, cfg.yaw_limit, cfg.vel_limit);
    end
  end

  // Stage two payload: one square per multiplier.
  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_item    <= s1_item;
      s2_sqx_on  <= SQ_W'(s1_adx_on) * SQ_W'(s1_adx_on);
      s2_sqy_on  <= SQ_W'(s1_ady_on) * SQ_W'(s1_ady_on);
      s2_sqx_off <= SQ_W'(s1_adx_off) * SQ_W'(s1_adx_off);
      s2_sqy_off <= SQ_W'(s1_ady_off) * SQ_W'(s1_ady_off);
      s2_yv_on   <= s1_yv_on;
      s2_yv_off  <= s1_yv_off;
    end
  end

  // Distance compare and hand-off to the queue.
  assign d2_on  = {1'b0, s2_sqx_on} + {1'b0, s2_sqy_on};
  assign d2_off = {1'b0, s2_sqx_off} + {1'b0, s2_sqy_off};
  assign push   = s2_valid && !q_full;

  always_comb begin
    push_item          = s2_item;
    push_item.on_cont  = (d2_on <= {9'b0, lim_sq}) && s2_yv_on;
    push_item.off_cont = (d2_off <= {9'b0, lim_sq}) && s2_yv_off;
  end

endmodule

// File: rtl/core/dms_queue.sv
module dms_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dms_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output dms_pkg::item_t head_item
);
  import dms_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign head_item = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// File: rtl/core/dms_back.sv
module dms_back (
  input  logic             clk,
  input  logic             rst,
  input  dms_pkg::cfg_t    cfg,
  input  logic             q_empty,
  output logic             pop,
  input  dms_pkg::item_t   head,
  output logic             out_valid,
  input  logic             out_stall,
  output dms_pkg::result_t result
);
  import dms_pkg::*;

  // Supervisor state.
  mode_t       current_mode;
  trans_t      pending_transition;
  mode_t       wanted_mode;
  logic [31:0] transition_start;
  logic        force_pending;

  mode_t       current_mode_next;
  trans_t      pending_transition_next;
  mode_t       wanted_mode_next;
  logic [31:0] transition_start_next;
  logic        force_pending_next;
  result_t     result_next;

  logic        held;
  logic        to_off;
  logic        tgt_ok;
  logic        alt_ok;
  logic        tgt_cont;
  logic [31:0] elapsed;

  // A word is taken whenever the output register is free or being emptied.
  assign pop = !q_empty && (!out_valid || !out_stall);

  always_comb begin
    current_mode_next       = current_mode;
    pending_transition_next = (pending_transition == TR_TO_OFF ||
                               pending_transition == TR_TO_ON) ? pending_transition : TR_NONE;
    wanted_mode_next        = wanted_mode;
    transition_start_next   = transition_start;
    force_pending_next      = force_pending;

    result_next.accepted       = 1'b1;
    result_next.trans          = TR_NONE;
    result_next.route          = ROUTE_STOP;
    result_next.offroad_active = 1'b0;
    result_next.reason         = RSN_NONE;

    held     = 1'b0;
    to_off   = 1'b0;
    tgt_ok   = 1'b0;
    alt_ok   = 1'b0;
    tgt_cont = 1'b0;
    elapsed  = head.now_ms - transition_start;

    if (head.cmd == CMD_REQUEST) begin
      // Mode request: only on-road and off-road are supported targets.
      if (head.target != MODE_ONROAD && head.target != MODE_OFFROAD) begin
        result_next.accepted = 1'b0;
        result_next.reason   = RSN_UNSUPPORTED;
      end else begin
        wanted_mode_next = head.target;
        if (head.target == current_mode && pending_transition_next == TR_NONE) begin
          result_next.reason = RSN_ALREADY;
        end else begin
          pending_transition_next = (head.target == MODE_OFFROAD) ? TR_TO_OFF : TR_TO_ON;
          transition_start_next   = head.now_ms;
          force_pending_next      = head.force_req;
          result_next.reason      = RSN_STARTED;
        end
      end
      result_next.trans = pending_transition_next;
    end else begin
      // Localization loss drops to standby; standby leaves once a source is usable.
      if (!head.ego_valid) begin
        current_mode_next       = MODE_STANDBY;
        pending_transition_next = TR_NONE;
        result_next.reason      = RSN_NO_LOC;
        held                    = 1'b1;
      end else if (current_mode_next == MODE_STANDBY &&
                   pending_transition_next == TR_NONE) begin
        if (cfg.startup_offroad && head.off_ok) begin
          current_mode_next = MODE_OFFROAD;
          wanted_mode_next  = MODE_OFFROAD;
        end else if (head.on_ok) begin
          current_mode_next = MODE_ONROAD;
          wanted_mode_next  = MODE_ONROAD;
        end else begin
          result_next.reason = RSN_AWAIT_SOURCE;
          held               = 1'b1;
        end
      end

      // Pending transition: commit, time out, or keep waiting.
      if (!held && pending_transition_next != TR_NONE) begin
        to_off   = (pending_transition_next == TR_TO_OFF);
        tgt_ok   = to_off ? head.off_ok : head.on_ok;
        alt_ok   = to_off ? head.on_ok : head.off_ok;
        tgt_cont = to_off ? head.off_cont : head.on_cont;
        if (tgt_ok && (force_pending || tgt_cont)) begin
          current_mode_next       = to_off ? MODE_OFFROAD : MODE_ONROAD;
          pending_transition_next = TR_NONE;
          force_pending_next      = 1'b0;
        end else if (elapsed > {16'b0, cfg.trans_limit}) begin
          pending_transition_next = TR_NONE;
          force_pending_next      = 1'b0;
          if (alt_ok) begin
            current_mode_next  = to_off ? MODE_ONROAD : MODE_OFFROAD;
            wanted_mode_next   = to_off ? MODE_ONROAD : MODE_OFFROAD;
            result_next.reason = to_off ? RSN_OFF_TO_ON : RSN_ON_STAY_OFF;
          end else begin
            current_mode_next  = MODE_SAFESTOP;
            result_next.reason = to_off ? RSN_OFF_NO_FALLBK : RSN_ON_NO_FALLBK;
          end
        end else begin
          result_next.trans          = pending_transition_next;
          result_next.offroad_active = 1'b1;
          held                       = 1'b1;
          if (current_mode_next == MODE_ONROAD && head.on_ok) begin
            result_next.route = ROUTE_ON;
          end else if (current_mode_next == MODE_OFFROAD && head.off_ok) begin
            result_next.route = ROUTE_OFF;
          end
        end
      end

      // Steady source check.
      if (!held) begin
        if (current_mode_next == MODE_ONROAD) begin
          if (head.on_ok) begin
            result_next.route = ROUTE_ON;
          end else begin
            current_mode_next  = MODE_SAFESTOP;
            result_next.reason = RSN_ON_LOST;
          end
        end else if (current_mode_next == MODE_OFFROAD) begin
          if (head.off_ok) begin
            result_next.route          = ROUTE_OFF;
            result_next.offroad_active = 1'b1;
          end else begin
            current_mode_next  = MODE_SAFESTOP;
            result_next.reason = RSN_OFF_LOST;
          end
        end
      end
    end

    result_next.mode      = current_mode_next;
    result_next.requested = wanted_mode_next;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode       <= MODE_STANDBY;
      pending_transition <= TR_NONE;
      wanted_mode        <= MODE_STANDBY;
      transition_start   <= '0;
      force_pending      <= 1'b0;
    end else if (pop) begin
      current_mode       <= current_mode_next;
      pending_transition <= pending_transition_next;
      wanted_mode        <= wanted_mode_next;
      transition_start   <= transition_start_next;
      force_pending      <= force_pending_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

endmodule

// File: rtl/core/dms_checker.sv
module dms_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       accepted,
  input logic [1:0] mode_now,
  input logic [1:0] transition_now,
  input logic [1:0] route,
  input logic       offroad_active,
  input logic [3:0] reason_code
);
  import dms_pkg::*;

  // A stalled result word stays presented.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(reason_code) && $stable(mode_now) && $stable(route))
    else $error("result word changed while stalled");

  // Only an unsupported request is refused.
  a_refused: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> reason_code == RSN_UNSUPPORTED)
    else $error("refused request without the unsupported reason");

  // The off-road route is only given while off-road is the current mode.
  a_route_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && route == ROUTE_OFF |-> mode_now == MODE_OFFROAD)
    else $error("off-road route outside off-road mode");

  // The off-road planner runs only on the off-road route or during a transition.
  a_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && offroad_active |-> route == ROUTE_OFF || transition_now != TR_NONE)
    else $error("off-road planner active without cause");

endmodule

bind driving_mode_supervisor_unit dms_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .accepted       (accepted),
  .mode_now       (mode_now),
  .transition_now (transition_now),
  .route          (route),
  .offroad_active (offroad_active),
  .reason_code    (reason_code)
);
